FILE: sv/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// Used by the channel interfaces, the register file, the engine and the top level.
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// payload field widths
	localparam int REQ_TYPE_W = 2;
	localparam int CHAR_W     = 8;
	localparam int INDEX_W    = 11;
	localparam int ROW_OUT_W  = 5;
	localparam int COL_OUT_W  = 7;
	localparam int POS_OUT_W  = 11;
	localparam int CELL_W     = 16;
	localparam int ATTR_W     = 8;
	localparam int TAB_W      = 4;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [ATTR_W-1:0] CHAR_ATTR_RST  = 8'h0F;
	localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h00;
	localparam logic [TAB_W-1:0]  TAB_STEP_RST   = 4'd4;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_PUT   = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		REG_CHAR_ATTR  = 2'd0,
		REG_BLANK_ATTR = 2'd1,
		REG_TAB_STEP   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [ATTR_W-1:0] char_attr;
		logic [ATTR_W-1:0] blank_attr;
		logic [TAB_W-1:0]  tab_step;
	} cfg_t;

endpackage

FILE: sv/tcw_req_if.sv
// Request channel: valid/ready handshake with the request payload.
// Depends on tcw_pkg for field widths.
interface tcw_req_if;
	logic                           valid;
	logic                           ready;
	logic [tcw_pkg::REQ_TYPE_W-1:0] req_type;
	logic [tcw_pkg::CHAR_W-1:0]     char_code;
	logic [tcw_pkg::INDEX_W-1:0]    cell_index;

	modport source(output valid, req_type, char_code, cell_index, input ready);
	modport sink(input valid, req_type, char_code, cell_index, output ready);
endinterface

FILE: sv/tcw_rsp_if.sv
// Result channel: valid/ready handshake with cursor, cell data and scroll flag.
// Depends on tcw_pkg for field widths.
interface tcw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row;
	logic [tcw_pkg::COL_OUT_W-1:0] cursor_col;
	logic [tcw_pkg::POS_OUT_W-1:0] cursor_pos;
	logic [tcw_pkg::CELL_W-1:0]    cell_data;
	logic                          scrolled;

	modport source(output valid, cursor_row, cursor_col, cursor_pos, cell_data, scrolled,
		input ready);
	modport sink(input valid, cursor_row, cursor_col, cursor_pos, cell_data, scrolled,
		output ready);
endinterface

FILE: sv/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/tcw_cfg.sv
// APB-style register file for attribute bytes and tab step.
// Depends on tcw_pkg for the register map and the cfg_t bundle.
module tcw_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
	input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
	output logic [tcw_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output tcw_pkg::cfg_t                cfg
);

	tcw_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.char_attr  <= tcw_pkg::CHAR_ATTR_RST;
			cfg_q.blank_attr <= tcw_pkg::BLANK_ATTR_RST;
			cfg_q.tab_step   <= tcw_pkg::TAB_STEP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				tcw_pkg::REG_CHAR_ATTR:  cfg_q.char_attr  <= pwdata[7:0];
				tcw_pkg::REG_BLANK_ATTR: cfg_q.blank_attr <= pwdata[7:0];
				tcw_pkg::REG_TAB_STEP:   cfg_q.tab_step   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			tcw_pkg::REG_CHAR_ATTR:  prdata = 32'(cfg_q.char_attr);
			tcw_pkg::REG_BLANK_ATTR: prdata = 32'(cfg_q.blank_attr);
			tcw_pkg::REG_TAB_STEP:   prdata = 32'(cfg_q.tab_step);
			default:                 prdata = '0;
		endcase
	end

endmodule

FILE: sv/tcw_engine.sv
// Cursor state, request decode and cell-buffer sequencer (fill, scroll, read).
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if; drives the ports of one tcw_ram.
module tcw_engine #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF,
	localparam int CELLS  = ROWS * COLUMNS,
	localparam int AW     = $clog2(CELLS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::cfg_t               cfg,
	tcw_req_if.sink                     req,
	tcw_rsp_if.source                   rsp,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [tcw_pkg::CELL_W-1:0]  mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [tcw_pkg::CELL_W-1:0]  mem_rdata
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int NCOPY = (ROWS - 1) * COLUMNS;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_RESP   = 5'b00010,
		ST_FILL   = 5'b00100,
		ST_SCRD   = 5'b01000,
		ST_SCROLL = 5'b10000
	} state_t;

	state_t          state_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [AW-1:0]   base_q;   // row_q * COLUMNS
	logic [AW-1:0]   pos_q;    // base_q + col_q
	logic [AW-1:0]   cnt_q;
	logic            init_q;
	logic            scr_q;
	logic            rd_ok_q;

	logic                          rsp_valid_q;
	logic [tcw_pkg::ROW_OUT_W-1:0] rsp_row_q;
	logic [tcw_pkg::COL_OUT_W-1:0] rsp_col_q;
	logic [tcw_pkg::POS_OUT_W-1:0] rsp_pos_q;
	logic [tcw_pkg::CELL_W-1:0]    rsp_cell_q;
	logic                          rsp_scr_q;

	logic                      acc;
	logic                      out_free;
	logic                      in_range;
	logic                      last_row;
	logic                      tab_over;
	logic                      do_nl;
	logic                      go_scroll;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [tcw_pkg::CHAR_W-1:0] wr_char;
	logic [RW-1:0]             nxt_row;
	logic [CW-1:0]             nxt_col;
	logic [AW-1:0]             nxt_base;
	logic [AW-1:0]             nxt_pos;
	logic [tcw_pkg::CHAR_W-1:0] ch;
	logic                      cnt_last;
	logic [tcw_pkg::ATTR_W-1:0] fill_attr;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign in_range  = 32'(req.cell_index) < 32'(CELLS);
	assign last_row  = (row_q == RW'(ROWS - 1));
	assign tab_over  = (8'(col_q) + 8'(cfg.tab_step)) >= 8'(COLUMNS);
	assign ch        = req.char_code;
	assign cnt_last  = (cnt_q == AW'(CELLS - 1));
	// reset contents are spaces with attribute zero, whatever blank_attr says
	assign fill_attr = init_q ? tcw_pkg::BLANK_ATTR_RST : cfg.blank_attr;

	// put-character decode: next cursor and optional cell write
	always_comb begin
		do_nl     = 1'b0;
		go_scroll = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_char   = ch;
		nxt_row   = row_q;
		nxt_col   = col_q;
		nxt_base  = base_q;
		nxt_pos   = pos_q;
		priority if (ch == tcw_pkg::CH_NUL) begin
		end else if (ch == tcw_pkg::CH_NL) begin
			do_nl = 1'b1;
		end else if (ch == tcw_pkg::CH_TAB) begin
			if (tab_over) begin
				do_nl = 1'b1;
			end else begin
				nxt_col = col_q + CW'(cfg.tab_step);
				nxt_pos = pos_q + AW'(cfg.tab_step);
			end
		end else if (ch == tcw_pkg::CH_BS) begin
			if (pos_q != '0) begin
				wr_en   = 1'b1;
				wr_addr = pos_q - AW'(1);
				wr_char = tcw_pkg::CH_SPACE;
				nxt_pos = pos_q - AW'(1);
				if (col_q != '0) begin
					nxt_col = col_q - CW'(1);
				end else begin
					nxt_row  = row_q - RW'(1);
					nxt_col  = CW'(COLUMNS - 1);
					nxt_base = base_q - AW'(COLUMNS);
				end
			end
		end else begin
			wr_en = 1'b1;
			if (col_q == CW'(COLUMNS - 1)) begin
				do_nl = 1'b1;
			end else begin
				nxt_col = col_q + CW'(1);
				nxt_pos = pos_q + AW'(1);
			end
		end
		if (do_nl) begin
			nxt_col = '0;
			if (last_row) begin
				go_scroll = 1'b1;
				nxt_pos   = base_q;
			end else begin
				nxt_row  = row_q + RW'(1);
				nxt_base = base_q + AW'(COLUMNS);
				nxt_pos  = base_q + AW'(COLUMNS);
			end
		end
	end

	// buffer port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = {fill_attr, tcw_pkg::CH_SPACE};
		mem_re    = 1'b0;
		mem_raddr = cnt_q + AW'(COLUMNS + 1);
		unique case (state_q)
			ST_IDLE: begin
				if (acc && req.req_type == tcw_pkg::REQ_PUT) begin
					mem_we    = wr_en;
					mem_waddr = wr_addr;
					mem_wdata = {cfg.char_attr, wr_char};
				end
				if (acc && req.req_type == tcw_pkg::REQ_READ && in_range) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(req.cell_index);
				end
			end
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_SCRD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(COLUMNS);
			end
			ST_SCROLL: begin
				// read runs one row and one cell ahead of the write
				mem_we    = 1'b1;
				mem_wdata = (cnt_q < AW'(NCOPY)) ? mem_rdata
					: {cfg.blank_attr, tcw_pkg::CH_SPACE};
				mem_re    = cnt_q < AW'(NCOPY - 1);
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			init_q  <= 1'b1;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			base_q  <= '0;
			pos_q   <= '0;
			scr_q   <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						scr_q   <= 1'b0;
						rd_ok_q <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_RESP;
						unique case (req.req_type)
							tcw_pkg::REQ_PUT: begin
								row_q  <= nxt_row;
								col_q  <= nxt_col;
								base_q <= nxt_base;
								pos_q  <= nxt_pos;
								scr_q  <= go_scroll;
								if (go_scroll) begin
									state_q <= ST_SCRD;
								end
							end
							tcw_pkg::REQ_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								base_q  <= '0;
								pos_q   <= '0;
								state_q <= ST_FILL;
							end
							tcw_pkg::REQ_READ: begin
								rd_ok_q <= in_range;
							end
							tcw_pkg::REQ_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_last) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_RESP;
					end
				end
				ST_SCRD: begin
					state_q <= ST_SCROLL;
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_last) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			rsp_row_q  <= tcw_pkg::ROW_OUT_W'(row_q);
			rsp_col_q  <= tcw_pkg::COL_OUT_W'(col_q);
			rsp_pos_q  <= tcw_pkg::POS_OUT_W'(pos_q);
			rsp_cell_q <= rd_ok_q ? mem_rdata : '0;
			rsp_scr_q  <= scr_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_row = rsp_row_q;
	assign rsp.cursor_col = rsp_col_q;
	assign rsp.cursor_pos = rsp_pos_q;
	assign rsp.cell_data  = rsp_cell_q;
	assign rsp.scrolled   = rsp_scr_q;

`ifndef SYNTHESIS
	a_pos_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == base_q + AW'(col_q))
		else $error("cursor position out of step with row base and column");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(COLUMNS - 1) && row_q <= RW'(ROWS - 1))
		else $error("cursor outside the buffer");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && mem_waddr == mem_raddr))
		else $error("read and write to the same cell in one cycle");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_scr_q |->
			rsp_row_q == tcw_pkg::ROW_OUT_W'(ROWS - 1) && rsp_col_q == '0)
		else $error("scroll result without cursor at start of bottom row");

	a_ready_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP && out_free |=> req.ready && rsp_valid_q)
		else $error("result load did not free the request side");
`endif

endmodule

FILE: sv/text_console_char_writer_unit.sv
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if, tcw_ram, tcw_cfg and tcw_engine.
//
// Usage:
//   req carries one request per transfer: put character, clear screen or read
//   cell. rsp returns exactly one result per request, in order, with the
//   cursor after the request, the cell read (zero for other requests) and a
//   scroll flag. The APB port sets char_attr (0x0), blank_attr (0x4) and
//   tab_step (0x8); write it only while no request is in flight.
// Timing:
//   Put, read and unused requests: the engine passes through its response state and
//   loads the result into the output register; no new request is taken before then.
//   A put that scrolls copies the cell buffer up one row, one cell per cycle through
//   its single read and write port, then blanks the bottom row.
//   Clear writes a blank to every cell of the buffer before its result.
// Reset:
//   Cursor homes and registers take their defaults; then a clearing pass blanks
//   every cell of the buffer with req.ready low.
// Stalls:
//   A result waits in the output register while rsp.ready is low; the engine
//   holds the following result and takes no new request until it moves on.
module text_console_char_writer_unit #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tcw_req_if.sink                     req,
	tcw_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0] paddr,
	input  logic [tcw_pkg::PDATA_W-1:0] pwdata,
	output logic [tcw_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	tcw_pkg::cfg_t              cfg;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [tcw_pkg::CELL_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic [tcw_pkg::CELL_W-1:0] mem_rdata;

	tcw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tcw_engine #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

FILE: verif/text_console_char_writer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for text_console_char_writer_unit: directed table, then random text traffic
// over several register settings, each result held to a pinned value or a cycle-free predictor.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if and the unit itself.
module text_console_char_writer_unit_tb;
	import tcw_pkg::*;

	localparam int COLUMNS     = COLUMNS_DEF;
	localparam int ROWS        = ROWS_DEF;
	localparam int CELLS       = COLUMNS * ROWS;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE      = 12;
	localparam int PHASE_ITEMS = 165;
	localparam int DIR_ROWS    = 24;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		req_type_t           kind;
		logic [CHAR_W-1:0]   ch;
		logic [INDEX_W-1:0]  idx;
	} req_item_t;

	typedef struct packed {
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic [POS_OUT_W-1:0] pos;
		logic [CELL_W-1:0]    cell_val;
		logic                 scrolled;
	} console_result_t;

	typedef struct packed {
		req_item_t       item;
		logic            pinned;
		console_result_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	tcw_req_if req_ch();
	tcw_rsp_if rsp_ch();

	text_console_char_writer_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// console shadow state
	logic [CELL_W-1:0] screen_shadow [CELLS];
	int unsigned cur_row;
	int unsigned cur_col;
	logic [ATTR_W-1:0] char_attr_sh;
	logic [ATTR_W-1:0] blank_attr_sh;
	logic [TAB_W-1:0] tab_step_sh;
	logic scroll_seen;

	console_result_t owed_results [$];
	int fault_count = 0;
	int issued = 0;
	int tx_steady = 0;
	int rsp_hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic note_fault(input string msg);
		if (fault_count < REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
		fault_count++;
	endtask

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_shadow[i] = {blank_attr_sh, CH_SPACE};
	endfunction

	function automatic void reset_shadow();
		char_attr_sh = CHAR_ATTR_RST;
		blank_attr_sh = BLANK_ATTR_RST;
		tab_step_sh = TAB_STEP_RST;
		cur_row = 0;
		cur_col = 0;
		blank_screen();
	endfunction

	function automatic void line_feed();
		cur_row++;
		cur_col = 0;
		if (cur_row >= ROWS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen_shadow[i] = screen_shadow[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen_shadow[i] = {blank_attr_sh, CH_SPACE};
			cur_row = ROWS - 1;
			scroll_seen = 1'b1;
		end
	endfunction

	function automatic void put_glyph(input logic [CHAR_W-1:0] ch);
		case (ch)
			CH_NUL: ;
			CH_NL: line_feed();
			CH_TAB: begin
				if (cur_col + tab_step_sh >= COLUMNS)
					line_feed();
				else
					cur_col += tab_step_sh;
			end
			CH_BS: begin
				if (cur_row != 0 || cur_col != 0) begin
					if (cur_col > 0) begin
						cur_col--;
					end else begin
						cur_row--;
						cur_col = COLUMNS - 1;
					end
					screen_shadow[cur_row * COLUMNS + cur_col] = {char_attr_sh, CH_SPACE};
				end
			end
			default: begin
				screen_shadow[cur_row * COLUMNS + cur_col] = {char_attr_sh, ch};
				cur_col++;
				if (cur_col >= COLUMNS)
					line_feed();
			end
		endcase
	endfunction

	function automatic console_result_t model_request(input req_item_t it);
		console_result_t res;
		logic [CELL_W-1:0] data;
		data = '0;
		scroll_seen = 1'b0;
		case (it.kind)
			REQ_PUT: put_glyph(it.ch);
			REQ_CLEAR: begin
				blank_screen();
				cur_row = 0;
				cur_col = 0;
			end
			REQ_READ: begin
				if (it.idx < CELLS)
					data = screen_shadow[it.idx];
			end
			default: ;
		endcase
		res.row = ROW_OUT_W'(cur_row);
		res.col = COL_OUT_W'(cur_col);
		res.pos = POS_OUT_W'(cur_row * COLUMNS + cur_col);
		res.cell_val = data;
		res.scrolled = scroll_seen;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (tx_steady > 0) begin
			tx_steady--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			tx_steady = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// offer one request, wait for the transfer, then record what it should return
	task automatic issue(input req_type_t kind, input logic [CHAR_W-1:0] ch,
		input logic [INDEX_W-1:0] idx, input logic pinned, input console_result_t want);
		req_item_t it;
		console_result_t predicted;
		int gap;
		it = '{kind: kind, ch: ch, idx: idx};
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.char_code <= ch;
		req_ch.cell_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		predicted = model_request(it);
		owed_results.push_back(pinned ? want : predicted);
		if (!(kind == REQ_NONE || (kind == REQ_PUT && ch == CH_NUL)))
			issued++;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_rand(input logic [CHAR_W-1:0] ch);
		issue(REQ_PUT, ch, INDEX_W'($urandom_range(0, 2047)), 1'b0, '0);
	endtask

	task automatic write_reg(input reg_index_t ri, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] want;
		logic [PDATA_W-1:0] seen;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(int'(ri) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (ri)
			REG_CHAR_ATTR: begin
				char_attr_sh = value[ATTR_W-1:0];
				want = PDATA_W'(char_attr_sh);
			end
			REG_BLANK_ATTR: begin
				blank_attr_sh = value[ATTR_W-1:0];
				want = PDATA_W'(blank_attr_sh);
			end
			default: begin
				tab_step_sh = value[TAB_W-1:0];
				want = PDATA_W'(tab_step_sh);
			end
		endcase
		// read it back
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seen = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (seen !== want)
			note_fault($sformatf("register %s readback: expected %h got %h",
				ri.name(), want, seen));
	endtask

	task automatic wait_quiet();
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_random(input int quota, input bit squeeze);
		int start;
		int len;
		int r;
		int pos;
		bit squeezed;
		logic [CHAR_W-1:0] c;
		start = issued;
		squeezed = 1'b0;
		while (issued - start < quota) begin
			if (squeeze && !squeezed && issued - start >= 30) begin
				// long receiver hold-off while requests keep coming back to back
				rsp_hold_cycles = 400;
				tx_steady = 25;
				squeezed = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) :
					$urandom_range(0, 12);
				for (int k = 0; k < len; k++) begin
					r = $urandom_range(0, 19);
					if (r == 0)
						c = CH_TAB;
					else if (r == 1)
						c = CH_BS;
					else if (r == 2)
						c = CHAR_W'($urandom_range(0, 255));
					else
						c = CHAR_W'($urandom_range(32, 255));
					put_rand(c);
				end
				if ($urandom_range(0, 4) != 0)
					put_rand(CH_NL);
			end else if (r < 80) begin
				pos = cur_row * COLUMNS + cur_col - $urandom_range(0, 2);
				if (pos < 0 || $urandom_range(0, 2) == 0)
					pos = $urandom_range(0, 2047);
				issue(REQ_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(pos), 1'b0, '0);
			end else if (r < 86) begin
				issue(req_type_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
					INDEX_W'($urandom_range(0, 2047)), 1'b0, '0);
			end else if (r < 90) begin
				len = $urandom_range(1, 90);
				for (int k = 0; k < len; k++)
					put_rand(CH_BS);
			end else if (r < 92) begin
				issue(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
					INDEX_W'($urandom_range(0, 2047)), 1'b0, '0);
			end else begin
				issue(REQ_NONE, CHAR_W'($urandom_range(0, 255)),
					INDEX_W'($urandom_range(0, 2047)), 1'b0, '0);
			end
		end
	endtask

	function automatic dir_row_t pinned_row(input req_type_t k, input logic [CHAR_W-1:0] c,
		input int idx, input int r, input int col, input int pos,
		input logic [CELL_W-1:0] cell_val, input logic scr);
		dir_row_t d;
		d.item = '{kind: k, ch: c, idx: INDEX_W'(idx)};
		d.pinned = 1'b1;
		d.want = '{row: ROW_OUT_W'(r), col: COL_OUT_W'(col), pos: POS_OUT_W'(pos),
			cell_val: cell_val, scrolled: scr};
		return d;
	endfunction

	function automatic dir_row_t free_row(input req_type_t k, input logic [CHAR_W-1:0] c,
		input int idx);
		dir_row_t d;
		d.item = '{kind: k, ch: c, idx: INDEX_W'(idx)};
		d.pinned = 1'b0;
		d.want = '0;
		return d;
	endfunction

	// result side: random back-pressure and in-order checking
	initial begin : result_sink
		int hold_left;
		int calm_left;
		int r;
		console_result_t got;
		console_result_t want;
		hold_left = 0;
		calm_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{row: rsp_ch.cursor_row, col: rsp_ch.cursor_col, pos: rsp_ch.cursor_pos,
					cell_val: rsp_ch.cell_data, scrolled: rsp_ch.scrolled};
				if (owed_results.size() == 0) begin
					note_fault($sformatf("result with nothing pending: row %0d col %0d",
						got.row, got.col));
				end else begin
					want = owed_results.pop_front();
					if (got !== want)
						note_fault($sformatf({"mismatch: expected row %0d col %0d pos %0d ",
							"cell %h scrolled %b, got row %0d col %0d pos %0d cell %h scrolled %b"},
							want.row, want.col, want.pos, want.cell_val, want.scrolled,
							got.row, got.col, got.pos, got.cell_val, got.scrolled));
				end
			end
			if (rsp_hold_cycles > 0) begin
				hold_left = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				rsp_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					calm_left = $urandom_range(20, 80);
					rsp_ch.ready <= 1'b1;
				end else if (r < 70) begin
					rsp_ch.ready <= 1'b1;
				end else if (r < 97) begin
					hold_left = $urandom_range(0, 3);
					rsp_ch.ready <= 1'b0;
				end else begin
					hold_left = $urandom_range(10, 60);
					rsp_ch.ready <= 1'b0;
				end
			end
		end
	end

	// ends the run when no transfer of any kind happens for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(psel && penable))
				idle = 0;
			else
				idle++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		dir_row_t dir_table [DIR_ROWS];
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_PUT;
		req_ch.char_code <= '0;
		req_ch.cell_index <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		reset_shadow();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_table = '{
			pinned_row(REQ_READ, 8'h00, 0, 0, 0, 0, 16'h0020, 1'b0),
			pinned_row(REQ_READ, 8'h00, CELLS - 1, 0, 0, 0, 16'h0020, 1'b0),
			pinned_row(REQ_READ, 8'h00, 2047, 0, 0, 0, 16'h0000, 1'b0),  // past the end
			pinned_row(REQ_NONE, 8'hFF, 2047, 0, 0, 0, 16'h0000, 1'b0),
			pinned_row(REQ_PUT, CH_NUL, 0, 0, 0, 0, 16'h0000, 1'b0),
			pinned_row(REQ_PUT, CH_BS, 0, 0, 0, 0, 16'h0000, 1'b0),      // backspace at home
			pinned_row(REQ_PUT, 8'h41, 0, 0, 1, 1, 16'h0000, 1'b0),
			pinned_row(REQ_READ, 8'h00, 0, 0, 1, 1, 16'h0F41, 1'b0),
			pinned_row(REQ_PUT, 8'hFF, 0, 0, 2, 2, 16'h0000, 1'b0),
			pinned_row(REQ_PUT, CH_TAB, 0, 0, 6, 6, 16'h0000, 1'b0),
			pinned_row(REQ_PUT, CH_BS, 0, 0, 5, 5, 16'h0000, 1'b0),
			pinned_row(REQ_PUT, CH_NL, 0, 1, 0, COLUMNS, 16'h0000, 1'b0),
			pinned_row(REQ_PUT, CH_BS, 0, 0, COLUMNS - 1, COLUMNS - 1, 16'h0000, 1'b0),
			pinned_row(REQ_READ, 8'h00, COLUMNS - 1, 0, COLUMNS - 1, COLUMNS - 1, 16'h0F20, 1'b0),
			pinned_row(REQ_PUT, 8'h5A, 0, 1, 0, COLUMNS, 16'h0000, 1'b0),  // wraps the line
			pinned_row(REQ_READ, 8'h00, COLUMNS - 1, 1, 0, COLUMNS, 16'h0F5A, 1'b0),
			free_row(REQ_PUT, 8'h80, 2047),
			free_row(REQ_PUT, 8'h7F, 1365),
			free_row(REQ_NONE, 8'h00, 0),
			pinned_row(REQ_READ, 8'h00, CELLS, 1, 2, COLUMNS + 2, 16'h0000, 1'b0),
			pinned_row(REQ_CLEAR, 8'h00, 0, 0, 0, 0, 16'h0000, 1'b0),
			pinned_row(REQ_READ, 8'h00, COLUMNS, 0, 0, 0, 16'h0020, 1'b0),
			free_row(REQ_PUT, CH_TAB, 682),
			free_row(REQ_READ, 8'h55, 1024)
		};
		foreach (dir_table[i])
			issue(dir_table[i].item.kind, dir_table[i].item.ch, dir_table[i].item.idx,
				dir_table[i].pinned, dir_table[i].want);
		run_random(PHASE_ITEMS, 1'b0);

		for (int phase = 1; phase <= 4; phase++) begin
			req_ch.valid <= 1'b0;
			wait_quiet();
			case (phase)
				1: begin
					write_reg(REG_CHAR_ATTR, 32'hFF);
					write_reg(REG_BLANK_ATTR, 32'hFF);
					write_reg(REG_TAB_STEP, 32'hF);
				end
				2: begin
					write_reg(REG_CHAR_ATTR, 32'h00);
					write_reg(REG_BLANK_ATTR, 32'($urandom_range(0, 255)));
					write_reg(REG_TAB_STEP, 32'h0);  // tabs never move the cursor
				end
				3: begin
					write_reg(REG_CHAR_ATTR, 32'($urandom_range(0, 255)));
					write_reg(REG_BLANK_ATTR, 32'h00);
					write_reg(REG_TAB_STEP, 32'h1);
				end
				default: begin
					write_reg(REG_CHAR_ATTR, 32'($urandom_range(0, 255)));
					write_reg(REG_BLANK_ATTR, 32'($urandom_range(0, 255)));
					write_reg(REG_TAB_STEP, 32'($urandom_range(1, 15)));
				end
			endcase
			run_random(PHASE_ITEMS, phase == 1);
		end

		req_ch.valid <= 1'b0;
		wait_quiet();
		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
